// File: src/rpg_pkg.sv
`default_nettype none

package rpg_pkg;

    // fixed point layout of the phase fraction and the gain
    localparam int PHASE_FRAC_BITS = 24;
    localparam int PATTERN_COUNT   = 32;
    localparam int ROM_IDX_W       = 5;
    localparam int MASK_W          = 16;
    localparam int STEP_IDX_W      = 5;
    localparam int GAIN_W          = 17;
    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

    // register widths
    localparam int SEL_W   = 6;
    localparam int INC_W   = 24;
    localparam int START_W = 24;
    localparam int SCALE_W = 18;
    localparam int CFG_DATA_W = 24;

    // fade product and its Q1.16 view
    localparam int FADE_PROD_W  = PHASE_FRAC_BITS + SCALE_W;
    localparam int FADE_SHIFT   = PHASE_FRAC_BITS - 8;
    localparam int FADE_T_RAW_W = FADE_PROD_W - FADE_SHIFT;

    typedef enum logic [1:0] {
        CFG_PATTERN = 2'd0,
        CFG_INC     = 2'd1,
        CFG_START   = 2'd2,
        CFG_SCALE   = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [SEL_W-1:0]   pattern_select;
        logic [INC_W-1:0]   phase_increment;
        logic [START_W-1:0] crossfade_start;
        logic [SCALE_W-1:0] crossfade_scale;
    } t_cfg;

    // per-frame gate decision from the front part
    typedef struct packed {
        logic                       bypass;
        logic                       cur;
        logic                       nxt;
        logic                       fade;
        logic [PHASE_FRAC_BITS-1:0] diff;
    } t_gate_ctl;

    // gate mask table
    function automatic logic [MASK_W-1:0] gate_mask(input logic [ROM_IDX_W-1:0] idx);
        logic [MASK_W-1:0] m;
        case (idx)
            5'd0:  m = 16'hFFFF;
            5'd1:  m = 16'h5555;
            5'd2:  m = 16'hAAAA;
            5'd3:  m = 16'h1111;
            5'd4:  m = 16'h0101;
            5'd5:  m = 16'h0001;
            5'd6:  m = 16'hCCCC;
            5'd7:  m = 16'h3333;
            5'd8:  m = 16'hEEEE;
            5'd9:  m = 16'h7777;
            5'd10: m = 16'hDDDD;
            5'd11: m = 16'hBBBB;
            5'd12: m = 16'h6666;
            5'd13: m = 16'h9999;
            5'd14: m = 16'hFF00;
            5'd15: m = 16'h00FF;
            5'd16: m = 16'hF0F0;
            5'd17: m = 16'h0F0F;
            5'd18: m = 16'h111F;
            5'd19: m = 16'hF111;
            5'd20: m = 16'h888F;
            5'd21: m = 16'hB6DB;
            5'd22: m = 16'h8421;
            5'd23: m = 16'h8001;
            5'd24: m = 16'hC003;
            5'd25: m = 16'h3C3C;
            5'd26: m = 16'h0FF0;
            5'd27: m = 16'hF00F;
            5'd28: m = 16'hAA55;
            5'd29: m = 16'h55AA;
            5'd30: m = 16'h9249;
            5'd31: m = 16'h2492;
            default: m = '0;
        endcase
        return m;
    endfunction

    // open bit of one step; steps past the mask are closed
    function automatic logic mask_bit(input logic [MASK_W-1:0] mask,
                                      input logic [STEP_IDX_W-1:0] step);
        logic b;
        if (step < STEP_IDX_W'(MASK_W)) begin
            b = mask[step[3:0]];
        end else begin
            b = 1'b0;
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// File: src/rhythmic_pattern_gate.sv
`default_nettype none

// Sixteen-step rhythmic gate for a stereo stream. One frame (one beat, left in the
// low half of tdata, right above it) gives one gated frame. A phase accumulator
// advances by phase_increment per frame and wraps at STEPS_PER_BAR steps; the
// pattern register picks a 16-bit open/closed mask, and near the end of a step
// the gain fades linearly toward the next step's bit. Pattern 0 passes audio
// through and freezes the phase. The block sustains one frame per clock while
// the output is not held off; the phase add with its wrap is the only loop. On
// its way from input beat to output beat a frame passes the front stage that
// updates the phase, the four-entry queue and the back pipeline stages (fade
// product, gain, sample multiply). The queue
// lets the front keep accepting while the output side is held off. Configuration
// writes are taken every cycle and should be made only with the block drained.
module rhythmic_pattern_gate #(
    parameter int STEPS_PER_BAR = 16,
    parameter int SAMPLE_BITS   = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration write channel
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [1:0]             i_cfg_index,
    input  wire logic [rpg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata: left_in, right_in, zero padding
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // output stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // tdata: left_out, right_out, zero padding
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata
);
    import rpg_pkg::*;

    localparam int PAIR_W  = 2 * SAMPLE_BITS;
    localparam int TDATA_W = ((PAIR_W + 7) / 8) * 8;
    localparam int ENTRY_W = $bits(t_gate_ctl) + PAIR_W;
    localparam int QUEUE_DEPTH = 4;

    t_cfg               r_cfg;
    t_gate_ctl          front_ctl;
    t_gate_ctl          back_ctl;
    logic [PAIR_W-1:0]  front_samples;
    logic [PAIR_W-1:0]  back_samples;
    logic [PAIR_W-1:0]  out_samples;
    logic               q_wr;
    logic               q_rd;
    logic               q_full;
    logic               q_empty;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_select  <= SEL_W'(0);
            r_cfg.phase_increment <= INC_W'(2796);
            r_cfg.crossfade_start <= START_W'(16553632);
            r_cfg.crossfade_scale <= SCALE_W'(32000);
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_PATTERN: r_cfg.pattern_select  <= i_cfg_data[SEL_W-1:0];
                CFG_INC:     r_cfg.phase_increment <= i_cfg_data[INC_W-1:0];
                CFG_START:   r_cfg.crossfade_start <= i_cfg_data[START_W-1:0];
                CFG_SCALE:   r_cfg.crossfade_scale <= i_cfg_data[SCALE_W-1:0];
                default:     r_cfg <= r_cfg;
            endcase
        end
    end

    rpg_front #(
        .STEPS_PER_BAR (STEPS_PER_BAR),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_samples (s_axis_tdata[PAIR_W-1:0]),
        .o_q_wr    (q_wr),
        .i_q_full  (q_full),
        .o_ctl     (front_ctl),
        .o_samples (front_samples)
    );

    rpg_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  ({front_ctl, front_samples}),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_empty (q_empty),
        .o_data  ({back_ctl, back_samples})
    );

    rpg_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .o_q_rd    (q_rd),
        .i_ctl     (back_ctl),
        .i_samples (back_samples),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_samples (out_samples)
    );

    assign m_axis_tdata = TDATA_W'(out_samples);

endmodule

`default_nettype wire

// File: src/rpg_front.sv
`default_nettype none

module rpg_front #(
    parameter int STEPS_PER_BAR = 16,
    parameter int SAMPLE_BITS   = 24
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire rpg_pkg::t_cfg              i_cfg,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [2*SAMPLE_BITS-1:0]   i_samples,
    output logic                            o_q_wr,
    input  wire logic                       i_q_full,
    output rpg_pkg::t_gate_ctl              o_ctl,
    output logic [2*SAMPLE_BITS-1:0]        o_samples
);
    import rpg_pkg::*;

    localparam int STEP_W  = $clog2(STEPS_PER_BAR);
    localparam int PHASE_W = STEP_W + PHASE_FRAC_BITS;
    localparam logic [PHASE_W:0] MODULUS = (PHASE_W+1)'(STEPS_PER_BAR) << PHASE_FRAC_BITS;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS_PER_BAR - 1);

    logic [PHASE_W-1:0]       r_phase;
    logic [PHASE_W-1:0]       r_snap;
    logic                     r_valid;
    logic                     r_bypass;
    logic [MASK_W-1:0]        r_mask;
    logic [2*SAMPLE_BITS-1:0] r_samples;

    logic                     accept;
    logic [PHASE_W:0]         phase_sum;
    logic [PHASE_W-1:0]       phase_wrap;
    logic [SEL_W-1:0]         sel_sat;
    logic [ROM_IDX_W-1:0]     rom_idx;
    logic [STEP_W-1:0]        step;
    logic [STEP_W-1:0]        step_next;
    logic [PHASE_FRAC_BITS-1:0] frac;

    assign o_ready = !r_valid || !i_q_full;
    assign accept  = i_valid && o_ready;

    // phase advance with a single wrap at the bar length
    always_comb begin
        phase_sum = {1'b0, r_phase} + (PHASE_W+1)'(i_cfg.phase_increment);
        if (phase_sum >= MODULUS) begin
            phase_wrap = PHASE_W'(phase_sum - MODULUS);
        end else begin
            phase_wrap = phase_sum[PHASE_W-1:0];
        end
    end

    // pattern number saturates at the table size
    always_comb begin
        if (i_cfg.pattern_select > SEL_W'(PATTERN_COUNT)) begin
            sel_sat = SEL_W'(PATTERN_COUNT);
        end else begin
            sel_sat = i_cfg.pattern_select;
        end
        rom_idx = ROM_IDX_W'(sel_sat - SEL_W'(1));
    end

    // phase state and accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
                if (i_cfg.pattern_select != '0) begin
                    r_phase <= phase_wrap;
                end
            end else if (o_q_wr) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_snap    <= phase_wrap;
            r_bypass  <= (i_cfg.pattern_select == '0);
            r_mask    <= gate_mask(rom_idx);
            r_samples <= i_samples;
        end
    end

    // classify the step: current and next open bits, fade region
    always_comb begin
        step      = r_snap[PHASE_W-1 -: STEP_W];
        frac      = r_snap[PHASE_FRAC_BITS-1:0];
        step_next = (step == LAST_STEP) ? '0 : step + STEP_W'(1);
        o_ctl.bypass = r_bypass;
        o_ctl.cur    = mask_bit(r_mask, STEP_IDX_W'(step));
        o_ctl.nxt    = mask_bit(r_mask, STEP_IDX_W'(step_next));
        o_ctl.fade   = (frac >= i_cfg.crossfade_start);
        o_ctl.diff   = frac - i_cfg.crossfade_start;
    end

    assign o_q_wr    = r_valid && !i_q_full;
    assign o_samples = r_samples;

endmodule

`default_nettype wire

// File: src/rpg_queue.sv
`default_nettype none

module rpg_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_rd,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);
    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + (PTR_W+1)'(1);
                2'b01:   r_count <= r_count - (PTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: src/rpg_back.sv
`default_nettype none

module rpg_back #(
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire rpg_pkg::t_cfg            i_cfg,
    input  wire logic                     i_q_empty,
    output logic                          o_q_rd,
    input  wire rpg_pkg::t_gate_ctl       i_ctl,
    input  wire logic [2*SAMPLE_BITS-1:0] i_samples,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [2*SAMPLE_BITS-1:0]      o_samples
);
    import rpg_pkg::*;

    localparam int MUL_W = SAMPLE_BITS + GAIN_W;

    // stage a: fade product
    logic                     r_a_valid;
    t_gate_ctl                r_a_ctl;
    logic [FADE_PROD_W-1:0]   r_a_prod;
    logic [2*SAMPLE_BITS-1:0] r_a_samples;
    // stage b: gain and sample magnitudes
    logic                     r_b_valid;
    logic [GAIN_W-1:0]        r_b_gain;
    logic                     r_b_sign_l;
    logic                     r_b_sign_r;
    logic [SAMPLE_BITS-1:0]   r_b_mag_l;
    logic [SAMPLE_BITS-1:0]   r_b_mag_r;
    // stage c: output register
    logic                     r_c_valid;
    logic [SAMPLE_BITS-1:0]   r_c_left;
    logic [SAMPLE_BITS-1:0]   r_c_right;

    logic                     a_ready;
    logic                     b_ready;
    logic                     c_ready;
    logic [FADE_T_RAW_W-1:0]  t_raw;
    logic [GAIN_W-1:0]        t_sat;
    logic [GAIN_W-1:0]        n_gain;
    logic [SAMPLE_BITS-1:0]   s_left;
    logic [SAMPLE_BITS-1:0]   s_right;
    logic [MUL_W-1:0]         prod_l;
    logic [MUL_W-1:0]         prod_r;
    logic [SAMPLE_BITS:0]     q_l;
    logic [SAMPLE_BITS:0]     q_r;

    assign c_ready = !r_c_valid || i_ready;
    assign b_ready = !r_b_valid || c_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_q_rd  = !i_q_empty && a_ready;

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= o_q_rd;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (c_ready) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    // stage a payload
    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_a_ctl     <= i_ctl;
            r_a_prod    <= FADE_PROD_W'(i_ctl.diff) * FADE_PROD_W'(i_cfg.crossfade_scale);
            r_a_samples <= i_samples;
        end
    end

    // fade amount in Q1.16, saturated at one, then the blended gain
    always_comb begin
        t_raw = r_a_prod[FADE_PROD_W-1:FADE_SHIFT];
        if (t_raw > FADE_T_RAW_W'(GAIN_ONE)) begin
            t_sat = GAIN_ONE;
        end else begin
            t_sat = t_raw[GAIN_W-1:0];
        end
        if (r_a_ctl.bypass) begin
            n_gain = GAIN_ONE;
        end else if (!r_a_ctl.fade) begin
            n_gain = r_a_ctl.cur ? GAIN_ONE : '0;
        end else begin
            n_gain = (r_a_ctl.cur ? GAIN_ONE - t_sat : '0) + (r_a_ctl.nxt ? t_sat : '0);
        end
        s_left  = r_a_samples[SAMPLE_BITS-1:0];
        s_right = r_a_samples[2*SAMPLE_BITS-1:SAMPLE_BITS];
    end

    // stage b payload
    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_valid) begin
            r_b_gain   <= n_gain;
            r_b_sign_l <= s_left[SAMPLE_BITS-1];
            r_b_sign_r <= s_right[SAMPLE_BITS-1];
            r_b_mag_l  <= s_left[SAMPLE_BITS-1] ? -s_left : s_left;
            r_b_mag_r  <= s_right[SAMPLE_BITS-1] ? -s_right : s_right;
        end
    end

    // magnitude times gain, truncated, sign restored
    always_comb begin
        prod_l = MUL_W'(r_b_mag_l) * MUL_W'(r_b_gain);
        prod_r = MUL_W'(r_b_mag_r) * MUL_W'(r_b_gain);
        q_l    = prod_l[MUL_W-1:16];
        q_r    = prod_r[MUL_W-1:16];
    end

    always_ff @(posedge i_clk) begin
        if (c_ready && r_b_valid) begin
            r_c_left  <= r_b_sign_l ? SAMPLE_BITS'(-q_l) : q_l[SAMPLE_BITS-1:0];
            r_c_right <= r_b_sign_r ? SAMPLE_BITS'(-q_r) : q_r[SAMPLE_BITS-1:0];
        end
    end

    assign o_valid   = r_c_valid;
    assign o_samples = {r_c_right, r_c_left};

endmodule

`default_nettype wire

// File: src/rpg_checker.sv
`default_nettype none

module rpg_checker #(
    parameter int TDATA_W = 48
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               s_axis_tvalid,
    input  wire logic               s_axis_tready,
    input  wire logic               m_axis_tvalid,
    input  wire logic               m_axis_tready,
    input  wire logic [TDATA_W-1:0] m_axis_tdata
);
    logic       in_beat;
    logic       out_beat;
    logic [3:0] r_outstanding;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    // frames accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            case ({in_beat, out_beat})
                2'b10:   r_outstanding <= r_outstanding + 4'd1;
                2'b01:   r_outstanding <= r_outstanding - 4'd1;
                default: r_outstanding <= r_outstanding;
            endcase
        end
    end

    // reset empties the output stage
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat valid right after reset");

    // no output beat without a frame in flight
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_outstanding != 4'd0)
        else $error("output beat with no frame outstanding");

    // a held output beat stays offered
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    // a held output beat keeps its data
    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

endmodule

bind rhythmic_pattern_gate rpg_checker #(
    .TDATA_W (((2*SAMPLE_BITS+7)/8)*8)
) u_rpg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: sim/tb_rhythmic_pattern_gate.sv
`timescale 1ns / 100ps

module tb_rhythmic_pattern_gate;

    localparam int STALL_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 16;
    localparam int RANDOM_FRAMES = 1850;

    // gate masks, entry n belongs to pattern n + 1
    localparam logic [15:0] GATE_MASKS [32] = '{
        16'hFFFF, 16'h5555, 16'hAAAA, 16'h1111, 16'h0101, 16'h0001, 16'hCCCC, 16'h3333,
        16'hEEEE, 16'h7777, 16'hDDDD, 16'hBBBB, 16'h6666, 16'h9999, 16'hFF00, 16'h00FF,
        16'hF0F0, 16'h0F0F, 16'h111F, 16'hF111, 16'h888F, 16'hB6DB, 16'h8421, 16'h8001,
        16'hC003, 16'h3C3C, 16'h0FF0, 16'hF00F, 16'hAA55, 16'h55AA, 16'h9249, 16'h2492
    };

    typedef struct packed {
        logic [23:0] right;
        logic [23:0] left;
    } stereo_frame_t;

    // gate shadow state plus the frames it still owes
    class gate_tracker;
        logic [5:0]    pattern_sel;
        logic [23:0]   phase_inc;
        logic [23:0]   fade_start;
        logic [17:0]   fade_scale;
        logic [27:0]   step_phase;
        stereo_frame_t gated_frames_q[$];
        int            errors;

        function new();
            pattern_sel = 6'd0;
            phase_inc   = 24'd2796;
            fade_start  = 24'd16553632;
            fade_scale  = 18'd32000;
            step_phase  = 28'd0;
            errors      = 0;
        endfunction

        function void set_reg(rpg_pkg::t_cfg_index idx, logic [23:0] data);
            case (idx)
                rpg_pkg::CFG_PATTERN: pattern_sel = data[5:0];
                rpg_pkg::CFG_INC:     phase_inc   = data;
                rpg_pkg::CFG_START:   fade_start  = data;
                rpg_pkg::CFG_SCALE:   fade_scale  = data[17:0];
                default: ;
            endcase
        endfunction

        // sign-magnitude multiply, truncating toward zero
        function logic [23:0] scale_sample(logic [23:0] s, logic [16:0] gain);
            longint sv;
            longint mag;
            longint prod;
            longint res;
            sv   = longint'($signed(s));
            mag  = (sv < 0) ? -sv : sv;
            prod = (mag * longint'(gain)) >>> 16;
            res  = (sv < 0) ? -prod : prod;
            return res[23:0];
        endfunction

        function void note_frame(logic [23:0] left, logic [23:0] right);
            int            slot;
            logic [15:0]   mask;
            logic [3:0]    step;
            logic [3:0]    nstep;
            logic [23:0]   frac;
            logic          cur;
            logic          nxt;
            logic [41:0]   prod;
            logic [25:0]   t;
            logic [16:0]   gain;
            stereo_frame_t f;
            if (pattern_sel == 6'd0) begin
                // bypass leaves the phase alone
                f.left  = left;
                f.right = right;
            end else begin
                slot = (pattern_sel > 6'd32) ? 31 : int'(pattern_sel) - 1;
                mask = GATE_MASKS[slot];
                // 4.24 phase wraps at sixteen steps, i.e. at 2^28
                step_phase = step_phase + 28'(phase_inc);
                step  = step_phase[27:24];
                frac  = step_phase[23:0];
                nstep = step + 4'd1;
                cur   = mask[step];
                nxt   = mask[nstep];
                if (frac >= fade_start) begin
                    prod = 42'(frac - fade_start) * 42'(fade_scale);
                    t    = prod[41:16];
                    if (t > 26'd65536) t = 26'd65536;
                    gain = (cur ? 17'(26'd65536 - t) : 17'd0) + (nxt ? 17'(t) : 17'd0);
                end else begin
                    gain = cur ? 17'h10000 : 17'd0;
                end
                f.left  = scale_sample(left, gain);
                f.right = scale_sample(right, gain);
            end
            gated_frames_q.push_back(f);
        endfunction

        function void check_frame(logic [47:0] data);
            stereo_frame_t want;
            if (gated_frames_q.size() == 0) begin
                $error("output beat with no frame pending: %h", data);
                errors++;
            end else begin
                want = gated_frames_q.pop_front();
                if (data[23:0] !== want.left) begin
                    $error("left_out: expected %0d, actual %0d",
                           $signed(want.left), $signed(data[23:0]));
                    errors++;
                end
                if (data[47:24] !== want.right) begin
                    $error("right_out: expected %0d, actual %0d",
                           $signed(want.right), $signed(data[47:24]));
                    errors++;
                end
            end
        endfunction

        function int pending();
            return gated_frames_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index   = 2'd0;
    logic [23:0] i_cfg_data    = 24'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = 48'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        steady        = 1'b0;
    int          stall_cycles;
    gate_tracker frames = new();

    rhythmic_pattern_gate uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // output side: random back-pressure and checking
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) frames.check_frame(m_axis_tdata);
        m_axis_tready <= steady || ($urandom_range(99) >= 26);
    end

    // watchdog on cycles without any beat
    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("Simulation FAILED");
        $finish;
    end

    task automatic write_reg(input rpg_pkg::t_cfg_index idx, input logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        frames.set_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // one input beat, with an optional idle gap ahead of it
    task automatic send_frame(input logic [23:0] left, input logic [23:0] right);
        if (!steady && $urandom_range(99) < 26) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 26);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {right, left};
        do @(posedge i_clk); while (!s_axis_tready);
        frames.note_frame(left, right);
    endtask

    // hold the input until every gated frame is out, then let the pipe settle
    task automatic drain_gate();
        s_axis_tvalid <= 1'b0;
        while (frames.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [23:0] rand_sample();
        logic [23:0] v;
        case ($urandom_range(9))
            0:       v = 24'h800000;
            1:       v = 24'h7FFFFF;
            2:       v = 24'h000000;
            3:       v = 24'hFFFFFF;
            4:       v = 24'h000001;
            default: v = 24'($urandom);
        endcase
        return v;
    endfunction

    // random register settings, extremes included
    task automatic randomize_regs();
        logic [23:0] data;
        logic [5:0]  sel;
        logic [17:0] scale;
        case ($urandom_range(19))
            0:       sel = 6'd0;
            1, 2:    sel = 6'($urandom_range(63, 33));
            default: sel = 6'($urandom_range(32, 1));
        endcase
        data = 24'($urandom);
        data[5:0] = sel;
        write_reg(rpg_pkg::CFG_PATTERN, data);
        case ($urandom_range(7))
            0:       data = 24'd0;
            1:       data = 24'hFFFFFF;
            2:       data = 24'($urandom_range(6990, 466));
            default: data = 24'($urandom);
        endcase
        write_reg(rpg_pkg::CFG_INC, data);
        case ($urandom_range(5))
            0:       data = 24'd0;
            1:       data = 24'hFFFFFF;
            default: data = 24'($urandom);
        endcase
        write_reg(rpg_pkg::CFG_START, data);
        case ($urandom_range(7))
            0:       scale = 18'd0;
            1:       scale = 18'd256;
            2:       scale = 18'h3FFFF;
            default: scale = 18'($urandom_range(262143));
        endcase
        data = 24'($urandom);
        data[17:0] = scale;
        write_reg(rpg_pkg::CFG_SCALE, data);
    endtask

    // main sequence
    initial begin
        int sent;
        int phase_no;
        int n;
        sent = 0;
        phase_no = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // bypass at reset settings
        send_frame(24'h7FFFFF, 24'h800000);
        send_frame(24'h800000, 24'h7FFFFF);
        send_frame(24'h000000, 24'hFFFFFF);
        send_frame(24'hAAAAAA, 24'h555555);
        send_frame(24'h555555, 24'hAAAAAA);
        send_frame(24'h000001, 24'h000000);
        drain_gate();

        // all-open mask, near-full step per frame, fade from step start, t saturating
        write_reg(rpg_pkg::CFG_PATTERN, 24'hABCD41);
        write_reg(rpg_pkg::CFG_INC, 24'hFFFFFF);
        write_reg(rpg_pkg::CFG_START, 24'h000000);
        write_reg(rpg_pkg::CFG_SCALE, 24'hFFFFFF);
        send_frame(24'h7FFFFF, 24'h800000);
        send_frame(24'h800000, 24'h7FFFFF);
        send_frame(24'hFFFFFF, 24'h000001);
        send_frame(24'h123456, 24'hEDCBA9);
        send_frame(24'hAAAAAA, 24'h555555);
        send_frame(24'h000000, 24'hFFFFFF);
        drain_gate();

        // pattern above range, phase frozen by zero increment, no fade
        write_reg(rpg_pkg::CFG_PATTERN, 24'h00003F);
        write_reg(rpg_pkg::CFG_INC, 24'h000000);
        write_reg(rpg_pkg::CFG_START, 24'hFFFFFF);
        write_reg(rpg_pkg::CFG_SCALE, 24'h000000);
        send_frame(24'h7FFFFF, 24'h800000);
        send_frame(24'h800000, 24'h7FFFFF);
        send_frame(24'h654321, 24'h9ABCDE);
        send_frame(24'hFFFFFF, 24'h000001);
        drain_gate();

        // half steps with a partial fade on alternating open and closed steps
        write_reg(rpg_pkg::CFG_PATTERN, 24'h000002);
        write_reg(rpg_pkg::CFG_INC, 24'h800000);
        write_reg(rpg_pkg::CFG_START, 24'h400000);
        write_reg(rpg_pkg::CFG_SCALE, 24'h000300);
        send_frame(24'h800000, 24'h7FFFFF);
        send_frame(24'h7FFFFF, 24'h800000);
        send_frame(24'hFFFFFF, 24'h000001);
        send_frame(24'h800001, 24'h7FFFFE);
        send_frame(24'h800000, 24'h7FFFFF);
        send_frame(24'hFFFFFF, 24'h000003);
        send_frame(24'h7FFFFF, 24'h800000);
        send_frame(24'hC00001, 24'h3FFFFF);

        // random phases, one of them with no idling on either side
        while (sent < RANDOM_FRAMES) begin
            drain_gate();
            randomize_regs();
            steady <= (phase_no == 4);
            n = $urandom_range(200, 100);
            repeat (n) begin
                send_frame(rand_sample(), rand_sample());
                sent++;
            end
            phase_no++;
        end
        steady <= 1'b0;

        drain_gate();
        if (frames.errors == 0 && frames.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/rpg_pkg.sv
src/rpg_front.sv
src/rpg_queue.sv
src/rpg_back.sv
src/rhythmic_pattern_gate.sv
src/rpg_checker.sv
sim/tb_rhythmic_pattern_gate.sv
